/* design/kct_pkg.sv */
// shared types and codes for the keyed compacting table
package kct_pkg;

    localparam int KEY0_W = 64;
    localparam int KEY1_W = 64;
    localparam int KEY2_W = 24;
    localparam int QTY_W  = 16;
    localparam int CNT_OUT_W = 5;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    // status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;

    typedef struct packed {
        logic [KEY0_W-1:0] w0;
        logic [KEY1_W-1:0] w1;
        logic [KEY2_W-1:0] w2;
    } t_key;

    typedef struct packed {
        t_key              key;
        logic [KEY0_W-1:0] kind0;
        logic [KEY1_W-1:0] kind1;
        logic [KEY2_W-1:0] kind2;
        logic [QTY_W-1:0]  qty;
    } t_entry;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp;  // latch key match
        logic ins;  // tail cell loads the new entry
        logic del;  // cells at or after the first hit take their neighbor
    } t_cell_ctrl;

endpackage

/* design/kct_cell.sv */
// one table slot: holds an entry, matches the key and shifts toward the head on remove
module kct_cell
    import kct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_live,
    input  logic       i_tail,
    input  t_key       i_key,
    input  t_entry     i_new,
    input  t_entry     i_next,
    input  logic       i_hit_before,
    output logic       o_hit_before,
    output logic       o_first,
    output t_entry     o_entry
);

    t_entry r_entry;
    logic   r_hit;
    logic   n_match;

    // exact compare over all key bytes
    assign n_match = (r_entry.key == i_key);

    // hit flag, refreshed on every compare cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.cmp) begin
            r_hit <= i_live && n_match;
        end
    end

    // entry storage: load at the tail, or close the gap left by a remove
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && i_tail) begin
            r_entry <= i_new;
        end else if (i_ctrl.del && (i_hit_before || r_hit)) begin
            r_entry <= i_next;
        end
    end

    assign o_hit_before = i_hit_before || r_hit;
    assign o_first      = r_hit && !i_hit_before;
    assign o_entry      = r_entry;

endmodule

/* design/keyed_compacting_table_unit.sv */
// keyed compacting table: ordered entry store built as a row of slot cells
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+-------------------------------------------------
//  request  | i_valid | o_ready | i_func, i_key_word0..2, i_kind_word0..2, i_quantity
//  result   | o_valid | i_ready | o_status, o_found_kind_word0..2, o_found_quantity,
//           |         |         | o_entry_count
//
// each operation runs through S_MATCH, which latches the key match in every cell, and
// S_APPLY, which resolves the first hit through the cell chain and updates the row.
// the next request is taken in S_APPLY when the result slot is free or being taken,
// so a new request can overlap the apply step of the one before it.
// reset clears the entry count and the handshake state; stored entries stay as they are.
// a stalled result holds the row in S_APPLY until the sink takes the result.
module keyed_compacting_table_unit
    import kct_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic [KEY0_W-1:0]    i_key_word0,
    input  logic [KEY1_W-1:0]    i_key_word1,
    input  logic [KEY2_W-1:0]    i_key_word2,
    input  logic [KEY0_W-1:0]    i_kind_word0,
    input  logic [KEY1_W-1:0]    i_kind_word1,
    input  logic [KEY2_W-1:0]    i_kind_word2,
    input  logic [QTY_W-1:0]     i_quantity,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [KEY0_W-1:0]    o_found_kind_word0,
    output logic [KEY1_W-1:0]    o_found_kind_word1,
    output logic [KEY2_W-1:0]    o_found_kind_word2,
    output logic [QTY_W-1:0]     o_found_quantity,
    output logic [CNT_OUT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [1:0]      r_func;
    t_entry          r_req;
    logic            r_out_valid;
    logic [2:0]      r_status;
    t_entry          r_found;

    t_cell_ctrl      n_ctrl;
    logic            n_advance;
    logic            n_accept;
    logic            n_full;
    logic            n_any_hit;
    logic [EW-1:0]   n_found;
    logic [31:0]     n_count_wide;

    t_entry          w_entry [CAPACITY];
    logic            w_first [CAPACITY];
    logic            w_hb    [CAPACITY+1];
    t_entry          w_next  [CAPACITY];

    // handshake
    assign n_advance = (r_state == S_APPLY) && (!r_out_valid || i_ready);
    assign o_ready   = (r_state == S_IDLE) || n_advance;
    assign n_accept  = i_valid && o_ready;
    assign n_full    = (r_count == CW'(CAPACITY));
    assign n_any_hit = w_hb[CAPACITY];

    // commands to the cell row
    always_comb begin
        n_ctrl     = '0;
        n_ctrl.cmp = (r_state == S_MATCH);
        n_ctrl.ins = n_advance && (r_func == FUNC_INSERT) && !n_full;
        n_ctrl.del = n_advance && (r_func == FUNC_REMOVE);
    end

    // row of slot cells, each feeding its entry to the one in front
    assign w_hb[0] = 1'b0;
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == CAPACITY - 1) begin : g_last
                assign w_next[g] = '0;
            end else begin : g_mid
                assign w_next[g] = w_entry[g+1];
            end
            kct_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (n_ctrl),
                .i_live       (CW'(g) < r_count),
                .i_tail       (CW'(g) == r_count),
                .i_key        (r_req.key),
                .i_new        (r_req),
                .i_next       (w_next[g]),
                .i_hit_before (w_hb[g]),
                .o_hit_before (w_hb[g+1]),
                .o_first      (w_first[g]),
                .o_entry      (w_entry[g])
            );
        end
    endgenerate

    // pick out the first matching entry
    always_comb begin
        n_found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                n_found = n_found | w_entry[i];
            end
        end
    end

    // sequencer, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken with no new result to replace it
            if (r_out_valid && i_ready && !n_advance) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (n_advance) begin
                        r_out_valid <= 1'b1;
                        r_state     <= n_accept ? S_MATCH : S_IDLE;
                        case (r_func)
                            FUNC_INSERT: begin
                                r_found <= '0;
                                if (n_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_INSERTED;
                                    r_count  <= r_count + 1'b1;
                                end
                            end
                            FUNC_REMOVE: begin
                                r_found <= '0;
                                if (n_any_hit) begin
                                    r_status <= ST_REMOVED;
                                    r_count  <= r_count - 1'b1;
                                end else begin
                                    r_status <= ST_NOTFOUND;
                                end
                            end
                            FUNC_SEARCH: begin
                                if (n_any_hit) begin
                                    r_status <= ST_FOUND;
                                    r_found  <= t_entry'(n_found);
                                end else begin
                                    r_status <= ST_NOTFOUND;
                                    r_found  <= '0;
                                end
                            end
                            default: begin
                                r_status <= ST_NOTFOUND;
                                r_found  <= '0;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request latch on transfer
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_func       <= i_func;
            r_req.key.w0 <= i_key_word0;
            r_req.key.w1 <= i_key_word1;
            r_req.key.w2 <= i_key_word2;
            r_req.kind0  <= i_kind_word0;
            r_req.kind1  <= i_kind_word1;
            r_req.kind2  <= i_kind_word2;
            r_req.qty    <= i_quantity;
        end
    end

    // result ports
    assign n_count_wide       = 32'(r_count);
    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_found_kind_word0 = r_found.kind0;
    assign o_found_kind_word1 = r_found.kind1;
    assign o_found_kind_word2 = r_found.kind2;
    assign o_found_quantity   = r_found.qty;
    assign o_entry_count      = n_count_wide[CNT_OUT_W-1:0];

endmodule

/* sim/keyed_compacting_table_unit_test.sv */
// self-checking testbench for the keyed compacting table unit
module keyed_compacting_table_unit_test;
    import kct_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_OPS   = 450;
    localparam int KEY_POOL     = 6;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    // code the block does not decode
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        t_key              key;
        logic [KEY0_W-1:0] kind0;
        logic [KEY1_W-1:0] kind1;
        logic [KEY2_W-1:0] kind2;
        logic [QTY_W-1:0]  qty;
    } t_request;

    typedef struct packed {
        logic [2:0]           status;
        logic [KEY0_W-1:0]    kind0;
        logic [KEY1_W-1:0]    kind1;
        logic [KEY2_W-1:0]    kind2;
        logic [QTY_W-1:0]     qty;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

    typedef struct {
        t_request req;
        bit       fixed;
        t_result  want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_func;
    logic [KEY0_W-1:0]    i_key_word0;
    logic [KEY1_W-1:0]    i_key_word1;
    logic [KEY2_W-1:0]    i_key_word2;
    logic [KEY0_W-1:0]    i_kind_word0;
    logic [KEY1_W-1:0]    i_kind_word1;
    logic [KEY2_W-1:0]    i_kind_word2;
    logic [QTY_W-1:0]     i_quantity;
    logic                 o_valid;
    logic                 i_ready;
    logic [2:0]           o_status;
    logic [KEY0_W-1:0]    o_found_kind_word0;
    logic [KEY1_W-1:0]    o_found_kind_word1;
    logic [KEY2_W-1:0]    o_found_kind_word2;
    logic [QTY_W-1:0]     o_found_quantity;
    logic [CNT_OUT_W-1:0] o_entry_count;

    // shadow copy of the table contents
    t_entry  shadow_slots [CAPACITY];
    int      shadow_used;
    t_result pending_results [$];
    t_row    directed_rows [$];

    int errors = 0;
    int status_seen [8];
    int phase;
    int idle_run;

    keyed_compacting_table_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_func(i_func),
        .i_key_word0(i_key_word0),
        .i_key_word1(i_key_word1),
        .i_key_word2(i_key_word2),
        .i_kind_word0(i_kind_word0),
        .i_kind_word1(i_kind_word1),
        .i_kind_word2(i_kind_word2),
        .i_quantity(i_quantity),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_found_kind_word0(o_found_kind_word0),
        .o_found_kind_word1(o_found_kind_word1),
        .o_found_kind_word2(o_found_kind_word2),
        .o_found_quantity(o_found_quantity),
        .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // apply one operation to the shadow table and return its result
    function automatic t_result table_apply(input t_request r);
        t_result res;
        int hit;
        res = '0;
        res.status = ST_NOTFOUND;
        hit = -1;
        for (int i = 0; i < shadow_used; i++) begin
            if (hit < 0 && shadow_slots[i].key == r.key) hit = i;
        end
        case (r.func)
            FUNC_INSERT: begin
                if (shadow_used >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_slots[shadow_used].key   = r.key;
                    shadow_slots[shadow_used].kind0 = r.kind0;
                    shadow_slots[shadow_used].kind1 = r.kind1;
                    shadow_slots[shadow_used].kind2 = r.kind2;
                    shadow_slots[shadow_used].qty   = r.qty;
                    shadow_used++;
                    res.status = ST_INSERTED;
                end
            end
            FUNC_REMOVE: begin
                if (hit >= 0) begin
                    // close the gap, later entries keep their order
                    for (int i = hit; i < shadow_used - 1; i++)
                        shadow_slots[i] = shadow_slots[i + 1];
                    shadow_used--;
                    res.status = ST_REMOVED;
                end
            end
            FUNC_SEARCH: begin
                if (hit >= 0) begin
                    res.status = ST_FOUND;
                    res.kind0  = shadow_slots[hit].kind0;
                    res.kind1  = shadow_slots[hit].kind1;
                    res.kind2  = shadow_slots[hit].kind2;
                    res.qty    = shadow_slots[hit].qty;
                end
            end
            default: begin
            end
        endcase
        res.count = CNT_OUT_W'(shadow_used);
        return res;
    endfunction

    function automatic t_request mk_req(input logic [1:0] func, input t_key key,
                                        input logic [KEY0_W-1:0] kind0,
                                        input logic [KEY1_W-1:0] kind1,
                                        input logic [KEY2_W-1:0] kind2,
                                        input logic [QTY_W-1:0] qty);
        t_request r;
        r.func  = func;
        r.key   = key;
        r.kind0 = kind0;
        r.kind1 = kind1;
        r.kind2 = kind2;
        r.qty   = qty;
        return r;
    endfunction

    // result with empty data fields
    function automatic t_result mk_res(input logic [2:0] status, input int count);
        t_result res;
        res = '0;
        res.status = status;
        res.count  = CNT_OUT_W'(count);
        return res;
    endfunction

    function automatic void add_row(input t_request r, input bit fixed, input t_result want);
        t_row row;
        row.req   = r;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic t_key rand_key();
        t_key k;
        k.w0 = {$urandom, $urandom};
        k.w1 = {$urandom, $urandom};
        k.w2 = KEY2_W'($urandom);
        return k;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // present one request, return at the edge of its transfer
    task automatic offer(input t_request r);
        while ($urandom_range(99) < (phase == 0 ? 24 : (phase == 1 ? 57 : 0))) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= r.func;
        i_key_word0  <= r.key.w0;
        i_key_word1  <= r.key.w1;
        i_key_word2  <= r.key.w2;
        i_kind_word0 <= r.kind0;
        i_kind_word1 <= r.kind1;
        i_kind_word2 <= r.kind2;
        i_quantity   <= r.qty;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stimulus and end of run
    initial begin
        t_key     ones_key;
        t_key     key_a;
        t_key     key_b;
        t_key     fill_key;
        t_key     pool [KEY_POOL];
        t_key     k;
        t_result  blank;
        t_result  found_ones;
        t_result  got;
        t_request r;
        logic [$bits(t_key)-1:0] flip;
        int roll;
        int ph;
        int ins_pct;
        int rem_pct;
        int total;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = FUNC_INSERT;
        i_key_word0  = '0;
        i_key_word1  = '0;
        i_key_word2  = '0;
        i_kind_word0 = '0;
        i_kind_word1 = '0;
        i_kind_word2 = '0;
        i_quantity   = '0;
        phase        = 0;
        shadow_used  = 0;

        // directed table
        ones_key = '1;
        blank    = '0;
        // zero byte in the middle, nonzero bytes after it
        key_a.w0 = 64'h4847_4645_4400_4241;
        key_a.w1 = 64'h504f_4e4d_4c4b_4a49;
        key_a.w2 = 24'h53_5251;
        // differs from key_a only in the last byte
        key_b = key_a;
        key_b.w2[23:16] = 8'h00;
        found_ones = mk_res(ST_FOUND, 2);
        found_ones.kind0 = '1;
        found_ones.kind1 = '1;
        found_ones.kind2 = '1;
        found_ones.qty   = '1;

        add_row(mk_req(FUNC_SEARCH, ones_key, '0, '0, '0, '0), 1'b1, mk_res(ST_NOTFOUND, 0));
        add_row(mk_req(FUNC_REMOVE, ones_key, '0, '0, '0, '0), 1'b1, mk_res(ST_NOTFOUND, 0));
        add_row(mk_req(FUNC_UNUSED, ones_key, '1, '1, '1, '1), 1'b1, mk_res(ST_NOTFOUND, 0));
        add_row(mk_req(FUNC_INSERT, ones_key, '1, '1, '1, '1), 1'b1, mk_res(ST_INSERTED, 1));
        add_row(mk_req(FUNC_INSERT, key_a, 64'h1111, 64'h2222, 24'h3333, 16'd1), 1'b0, blank);
        // duplicate key with other data
        add_row(mk_req(FUNC_INSERT, key_a, 64'haaaa, 64'hbbbb, 24'hcccc, 16'd2), 1'b0, blank);
        add_row(mk_req(FUNC_SEARCH, key_b, '1, '1, '1, '1), 1'b0, blank);
        add_row(mk_req(FUNC_SEARCH, key_a, '0, '0, '0, '0), 1'b0, blank);
        add_row(mk_req(FUNC_REMOVE, key_a, '0, '0, '0, '0), 1'b0, blank);
        add_row(mk_req(FUNC_SEARCH, key_a, '0, '0, '0, '0), 1'b0, blank);
        add_row(mk_req(FUNC_SEARCH, ones_key, '0, '0, '0, '0), 1'b1, found_ones);
        // fill to capacity, then refuse, then remove the head entry
        for (int i = 1; i <= CAPACITY - 2; i++) begin
            fill_key = '0;
            fill_key.w0 = 64'(i);
            add_row(mk_req(FUNC_INSERT, fill_key, 64'(i), '0, '0, '0), i == CAPACITY - 2,
                    mk_res(ST_INSERTED, CAPACITY));
        end
        add_row(mk_req(FUNC_INSERT, ones_key, '1, '1, '1, '1), 1'b1, mk_res(ST_FULL, CAPACITY));
        add_row(mk_req(FUNC_REMOVE, ones_key, '0, '0, '0, '0), 1'b1,
                mk_res(ST_REMOVED, CAPACITY - 1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].req);
            got = table_apply(directed_rows[i].req);
            pending_results.push_back(directed_rows[i].fixed ? directed_rows[i].want : got);
        end

        // random part: keys mostly from a small pool so hits and duplicates occur
        for (int i = 0; i < KEY_POOL; i++) pool[i] = rand_key();
        pool[0].w0[23:16] = 8'h00;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            ph = n * 3 / RANDOM_OPS;
            phase <= ph;
            ins_pct = (ph == 0) ? 50 : ((ph == 1) ? 30 : 40);
            rem_pct = (ph == 1) ? 40 : 25;
            roll = $urandom_range(99);
            if (roll < 5)
                r.func = FUNC_UNUSED;
            else if (roll < 5 + ins_pct)
                r.func = FUNC_INSERT;
            else if (roll < 5 + ins_pct + rem_pct)
                r.func = FUNC_REMOVE;
            else
                r.func = FUNC_SEARCH;
            k = pool[$urandom_range(KEY_POOL - 1)];
            roll = $urandom_range(99);
            if (roll >= 85) begin
                k = rand_key();
            end else if (roll >= 70) begin
                // near miss: one bit off a pooled key
                flip = '0;
                flip[$urandom_range($bits(t_key) - 1)] = 1'b1;
                k = k ^ flip;
            end
            r.key   = k;
            r.kind0 = {$urandom, $urandom};
            r.kind1 = {$urandom, $urandom};
            r.kind2 = KEY2_W'($urandom);
            r.qty   = QTY_W'($urandom);
            offer(r);
            got = table_apply(r);
            pending_results.push_back(got);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        total = 0;
        foreach (status_seen[i]) total += status_seen[i];
        $display("checked %0d results: %0d inserted, %0d refused full, %0d removed,",
                 total, status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_REMOVED]);
        $display("%0d not found, %0d found, with idling on both sides and one long sink stall",
                 status_seen[ST_NOTFOUND], status_seen[ST_FOUND]);
        if (errors == 0)
            $display("keyed_compacting_table_unit_test OK");
        else
            $display("keyed_compacting_table_unit_test NOT OK");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    initial begin
        t_result want;
        int hold_left;
        bit hold_done;
        i_ready   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing pending, expected none, actual status %0d",
                             $time, o_status);
                end else begin
                    want = pending_results.pop_front();
                    status_seen[want.status]++;
                    compare_field("status", 64'(want.status), 64'(o_status));
                    compare_field("found_kind_word0", want.kind0, o_found_kind_word0);
                    compare_field("found_kind_word1", want.kind1, o_found_kind_word1);
                    compare_field("found_kind_word2", 64'(want.kind2), 64'(o_found_kind_word2));
                    compare_field("found_quantity", 64'(want.qty), 64'(o_found_quantity));
                    compare_field("entry_count", 64'(want.count), 64'(o_entry_count));
                end
            end
            // long hold-off once the sender stops idling, so the block backs up
            if (phase == 2 && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= (phase == 0 ? 57 : (phase == 1 ? 24 : 0)));
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_run = 0;
        @(posedge i_rst_n);
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("keyed_compacting_table_unit_test NOT OK");
        $finish;
    end

endmodule

/* keyed_compacting_table_unit.f */
design/kct_pkg.sv
design/kct_cell.sv
design/keyed_compacting_table_unit.sv
sim/keyed_compacting_table_unit_test.sv
